// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside reset.
`define CSI_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define CSI_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/csiesc_pkg.sv =====
`timescale 1ns / 1ps

package csiesc_pkg;

   // Parser phases, including the two steps of the result run.
   typedef enum logic [2:0] {
      PH_GROUND,
      PH_ESCAPE,
      PH_ENTRY,
      PH_PARAM,
      PH_INTER,
      PH_EMIT_RD,
      PH_EMIT_LD
   } phase_type;

   // Byte codes.
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_QMARK    = 8'h3F;
   localparam logic [7:0] CH_BANG     = 8'h21;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] INTER_LO    = 8'h20;
   localparam logic [7:0] INTER_HI    = 8'h2F;
   localparam logic [7:0] FINAL_LO    = 8'h40;
   localparam logic [7:0] FINAL_HI    = 8'h7E;

   // Result kinds.
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_ERROR   = 1'b1;

   // Synchronized-output marks.
   localparam logic [1:0] SYNC_NONE    = 2'd0;
   localparam logic [1:0] SYNC_ENABLE  = 2'd1;
   localparam logic [1:0] SYNC_DISABLE = 2'd2;
   localparam logic [31:0] SYNC_PARAM  = 32'd2026;

   // Command codes.
   localparam logic [4:0] CMD_UNKNOWN    = 5'd0;
   localparam logic [4:0] CMD_CUU        = 5'd1;
   localparam logic [4:0] CMD_CUD        = 5'd2;
   localparam logic [4:0] CMD_CUF        = 5'd3;
   localparam logic [4:0] CMD_CUB        = 5'd4;
   localparam logic [4:0] CMD_CNL        = 5'd5;
   localparam logic [4:0] CMD_CPL        = 5'd6;
   localparam logic [4:0] CMD_CHA        = 5'd7;
   localparam logic [4:0] CMD_CUP        = 5'd8;
   localparam logic [4:0] CMD_ED         = 5'd9;
   localparam logic [4:0] CMD_EL         = 5'd10;
   localparam logic [4:0] CMD_SU         = 5'd11;
   localparam logic [4:0] CMD_SD         = 5'd12;
   localparam logic [4:0] CMD_HVP        = 5'd13;
   localparam logic [4:0] CMD_SGR        = 5'd14;
   localparam logic [4:0] CMD_DSR        = 5'd15;
   localparam logic [4:0] CMD_SM         = 5'd16;
   localparam logic [4:0] CMD_RM         = 5'd17;
   localparam logic [4:0] CMD_PRIV_SET   = 5'd18;
   localparam logic [4:0] CMD_PRIV_RESET = 5'd19;
   localparam logic [4:0] CMD_SAVE       = 5'd20;
   localparam logic [4:0] CMD_RESTORE    = 5'd21;
   localparam logic [4:0] CMD_SOFT_RESET = 5'd22;

   // Maps a final byte to its command code.
   function automatic logic [4:0] classify(input logic [7:0] f, input logic priv,
                                           input logic bang);
      logic [4:0] code;
      unique case (f)
         8'h41:   code = CMD_CUU;
         8'h42:   code = CMD_CUD;
         8'h43:   code = CMD_CUF;
         8'h44:   code = CMD_CUB;
         8'h45:   code = CMD_CNL;
         8'h46:   code = CMD_CPL;
         8'h47:   code = CMD_CHA;
         8'h48:   code = CMD_CUP;
         8'h4A:   code = CMD_ED;
         8'h4B:   code = CMD_EL;
         8'h53:   code = CMD_SU;
         8'h54:   code = CMD_SD;
         8'h66:   code = CMD_HVP;
         8'h6D:   code = CMD_SGR;
         8'h6E:   code = CMD_DSR;
         8'h68:   code = priv ? CMD_PRIV_SET : CMD_SM;
         8'h6C:   code = priv ? CMD_PRIV_RESET : CMD_RM;
         8'h73:   code = CMD_SAVE;
         8'h75:   code = CMD_RESTORE;
         8'h70:   code = bang ? CMD_SOFT_RESET : CMD_UNKNOWN;
         default: code = CMD_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// ===== src/csi_escape_sequence_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Ports                       Direction  Moves
// req      req_valid/req_stall         in         one byte of terminal output per item
// rsp      rsp_valid/rsp_stall         out        one parsed command or error per item
//
// Input bytes are taken back to back while input is not stalled. A command with
// N stored parameters gives N items: for each, the parameter memory is read in
// PH_EMIT_RD and its data loads the output register in PH_EMIT_LD, which waits
// while the output is stalled. A command without parameters and a parse error
// load the output register directly. Reset is synchronous and clears only the
// control state; the parameter memory needs no clearing. Input is stalled during
// a result run and while a waiting result is itself stalled.

module csi_escape_sequence_parser #(
   parameter int MAX_PARAMS = 16,
   parameter int PARAM_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [4:0] rsp_command_type,
   output logic [7:0] rsp_final_code,
   output logic       rsp_private_flag,
   output logic [4:0] rsp_param_total,
   output logic [3:0] rsp_param_index,
   output logic [15:0] rsp_param_value,
   output logic [1:0] rsp_sync_mode,
   output logic       rsp_truncated,
   output logic       rsp_last
);

   import csiesc_pkg::*;

   localparam int CW = $clog2(MAX_PARAMS + 1);
   localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int XW = PARAM_BITS + 4;
   localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};

   phase_type phase_ff, phase_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_dec;
   logic [CW-1:0] k_ff;
   logic private_ff;
   logic bang_ff;
   logic overflow_ff;
   logic [PARAM_BITS-1:0] cur_ff;
   logic [4:0] type_ff;
   logic [7:0] final_ff;
   logic [1:0] sync_ff;

   logic rsp_valid_ff;
   logic rsp_kind_ff;
   logic [4:0] rsp_command_type_ff;
   logic [7:0] rsp_final_code_ff;
   logic rsp_private_flag_ff;
   logic [4:0] rsp_param_total_ff;
   logic [3:0] rsp_param_index_ff;
   logic [15:0] rsp_param_value_ff;
   logic [1:0] rsp_sync_mode_ff;
   logic rsp_truncated_ff;
   logic rsp_last_ff;

   logic accept, out_free, emitting;
   logic is_digit, is_semi, is_inter, is_final;
   logic in_seq, in_any, byte_ok;
   logic do_clear, set_private, set_bang, do_push, push_ok, push_over;
   logic digit_ok, do_final, do_error, emit_load, k_last;
   logic [PARAM_BITS-1:0] push_value, digit_value;
   logic [XW-1:0] cur_ext, scaled;
   logic [4:0] final_type;
   logic [1:0] sync_now;

   logic wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [PARAM_BITS-1:0] wr_data, rd_data;

   // Parameter store: written on every digit and separator until a parameter no longer fits.
   csiesc_ram #(
      .WIDTH(PARAM_BITS),
      .DEPTH(MAX_PARAMS)
   ) u_param_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Handshake and byte classes.
   assign emitting  = (phase_ff == PH_EMIT_RD) || (phase_ff == PH_EMIT_LD);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = emitting || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign is_digit = (req_data_byte >= CH_ZERO) && (req_data_byte <= CH_NINE);
   assign is_semi  = (req_data_byte == CH_SEMI);
   assign is_inter = (req_data_byte >= INTER_LO) && (req_data_byte <= INTER_HI);
   assign is_final = (req_data_byte >= FINAL_LO) && (req_data_byte <= FINAL_HI);

   assign count_dec = count_ff - 1'b1;
   assign k_last    = (k_ff == count_dec);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_GROUND: begin
            if (accept && req_data_byte == CH_ESC) begin
               phase_in = PH_ESCAPE;
            end
         end
         PH_ESCAPE: begin
            if (accept) begin
               phase_in = (req_data_byte == CH_LBRACKET) ? PH_ENTRY : PH_GROUND;
            end
         end
         PH_ENTRY, PH_PARAM, PH_INTER: begin
            if (accept) begin
               priority if (set_private) begin
                  phase_in = PH_ENTRY;
               end else if (in_seq && (is_digit || is_semi)) begin
                  phase_in = PH_PARAM;
               end else if (is_inter) begin
                  phase_in = PH_INTER;
               end else if (is_final) begin
                  phase_in = (count_ff == '0) ? PH_GROUND : PH_EMIT_RD;
               end else begin
                  phase_in = PH_GROUND;
               end
            end
         end
         PH_EMIT_RD: begin
            phase_in = PH_EMIT_LD;
         end
         PH_EMIT_LD: begin
            if (out_free) begin
               phase_in = k_last ? PH_GROUND : PH_EMIT_RD;
            end
         end
         default: begin
            phase_in = PH_GROUND;
         end
      endcase
   end

   // Actions taken for the accepted byte and for the result run.
   always_comb begin
      in_seq      = (phase_ff == PH_ENTRY) || (phase_ff == PH_PARAM);
      in_any      = in_seq || (phase_ff == PH_INTER);
      do_clear    = accept && (phase_ff == PH_ESCAPE) && (req_data_byte == CH_LBRACKET);
      set_private = accept && (phase_ff == PH_ENTRY) && (req_data_byte == CH_QMARK)
                    && !private_ff;
      byte_ok     = is_inter || is_final || set_private || (in_seq && (is_digit || is_semi));
      do_push     = accept && in_seq && (is_digit || is_semi) && (phase_ff == PH_ENTRY || is_semi);
      push_ok     = do_push && (count_ff < CW'(MAX_PARAMS));
      push_over   = do_push && !push_ok;
      digit_ok    = accept && (phase_ff == PH_PARAM) && is_digit && !overflow_ff;
      set_bang    = accept && in_any && is_inter && (req_data_byte == CH_BANG);
      do_final    = accept && in_any && is_final;
      do_error    = accept && in_any && !byte_ok;
      emit_load   = (phase_ff == PH_EMIT_LD) && out_free;

      push_value = is_digit ? PARAM_BITS'(req_data_byte[3:0]) : '0;

      // Times ten plus the digit, saturated at the parameter maximum.
      cur_ext = XW'(cur_ff);
      scaled  = (cur_ext << 3) + (cur_ext << 1) + XW'(req_data_byte[3:0]);
      digit_value = (scaled[XW-1:PARAM_BITS] != '0) ? PARAM_MAX : scaled[PARAM_BITS-1:0];

      final_type = classify(req_data_byte, private_ff, bang_ff);

      wr_en   = push_ok || digit_ok;
      wr_addr = push_ok ? count_ff[AW-1:0] : count_dec[AW-1:0];
      wr_data = push_ok ? push_value : digit_value;
      rd_en   = (phase_ff == PH_EMIT_RD);
      rd_addr = k_ff[AW-1:0];

      // The sync mark comes from the first parameter, read first in the run.
      sync_now = sync_ff;
      if (k_ff == '0) begin
         sync_now = SYNC_NONE;
         if (private_ff && (32'(rd_data) == SYNC_PARAM)) begin
            if (type_ff == CMD_PRIV_SET) begin
               sync_now = SYNC_ENABLE;
            end else if (type_ff == CMD_PRIV_RESET) begin
               sync_now = SYNC_DISABLE;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GROUND;
         count_ff     <= '0;
         private_ff   <= 1'b0;
         bang_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (do_clear) begin
            count_ff    <= '0;
            private_ff  <= 1'b0;
            bang_ff     <= 1'b0;
            overflow_ff <= 1'b0;
         end else begin
            if (set_private) begin
               private_ff <= 1'b1;
            end
            if (set_bang) begin
               bang_ff <= 1'b1;
            end
            if (push_ok) begin
               count_ff <= count_ff + 1'b1;
            end
            if (push_over) begin
               overflow_ff <= 1'b1;
            end
         end
         if (do_final) begin
            k_ff <= '0;
         end else if (emit_load) begin
            k_ff <= k_ff + 1'b1;
         end
         if (do_error || (do_final && count_ff == '0) || emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers: current parameter, command header and output item.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         cur_ff <= push_value;
      end else if (digit_ok) begin
         cur_ff <= digit_value;
      end
      if (do_final) begin
         type_ff  <= final_type;
         final_ff <= req_data_byte;
      end
      if (emit_load) begin
         sync_ff <= sync_now;
      end
      priority if (do_error) begin
         rsp_kind_ff         <= KIND_ERROR;
         rsp_command_type_ff <= CMD_UNKNOWN;
         rsp_final_code_ff   <= req_data_byte;
         rsp_private_flag_ff <= 1'b0;
         rsp_param_total_ff  <= '0;
         rsp_param_index_ff  <= '0;
         rsp_param_value_ff  <= '0;
         rsp_sync_mode_ff    <= SYNC_NONE;
         rsp_truncated_ff    <= 1'b0;
         rsp_last_ff         <= 1'b1;
      end else if (do_final && count_ff == '0) begin
         rsp_kind_ff         <= KIND_COMMAND;
         rsp_command_type_ff <= final_type;
         rsp_final_code_ff   <= req_data_byte;
         rsp_private_flag_ff <= private_ff;
         rsp_param_total_ff  <= '0;
         rsp_param_index_ff  <= '0;
         rsp_param_value_ff  <= '0;
         rsp_sync_mode_ff    <= SYNC_NONE;
         rsp_truncated_ff    <= overflow_ff;
         rsp_last_ff         <= 1'b1;
      end else if (emit_load) begin
         rsp_kind_ff         <= KIND_COMMAND;
         rsp_command_type_ff <= type_ff;
         rsp_final_code_ff   <= final_ff;
         rsp_private_flag_ff <= private_ff;
         rsp_param_total_ff  <= 5'(count_ff);
         rsp_param_index_ff  <= 4'(k_ff);
         rsp_param_value_ff  <= 16'(rd_data);
         rsp_sync_mode_ff    <= sync_now;
         rsp_truncated_ff    <= overflow_ff;
         rsp_last_ff         <= k_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_command_type = rsp_command_type_ff;
   assign rsp_final_code   = rsp_final_code_ff;
   assign rsp_private_flag = rsp_private_flag_ff;
   assign rsp_param_total  = rsp_param_total_ff;
   assign rsp_param_index  = rsp_param_index_ff;
   assign rsp_param_value  = rsp_param_value_ff;
   assign rsp_sync_mode    = rsp_sync_mode_ff;
   assign rsp_truncated    = rsp_truncated_ff;
   assign rsp_last         = rsp_last_ff;

   // The run index never passes the number of stored parameters.
   `CSI_ASSERT_IMPLY(a_run_index, emitting, (k_ff < count_ff), "run index out of range")
   // The parameter count never exceeds the store.
   `CSI_ASSERT_ALWAYS(a_count_bound, (count_ff <= CW'(MAX_PARAMS)), "parameter count too large")
   // Truncation is only flagged with a full store.
   `CSI_ASSERT_IMPLY(a_overflow_full, overflow_ff, (count_ff == CW'(MAX_PARAMS)),
                     "truncation without full store")
   // A run only starts with at least one stored parameter.
   `CSI_ASSERT_IMPLY(a_run_start, (phase_ff == PH_EMIT_RD && k_ff == '0),
                     (count_ff != '0), "run started without parameters")

endmodule

// ===== src/csiesc_ram.sv =====
`timescale 1ns / 1ps

module csiesc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import csiesc_pkg::*;

   localparam int PARAM_SLOTS  = 16;
   localparam int VALUE_MAX    = 65535;
   localparam int IDLE_LIMIT   = 4000;
   localparam int BYTE_BUDGET  = 480;
   localparam int REPORT_LIMIT = 10;

   // One parsed command item or parse error, in port order.
   typedef struct packed {
      logic        kind;
      logic [4:0]  command_type;
      logic [7:0]  final_code;
      logic        private_flag;
      logic [4:0]  param_total;
      logic [3:0]  param_index;
      logic [15:0] param_value;
      logic [1:0]  sync_mode;
      logic        truncated;
      logic        last;
   } csi_result_type;

   // One byte of terminal output waiting to be sent.
   typedef struct {
      logic [7:0] data;
      bit         drain_first;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [4:0]  rsp_command_type;
   logic [7:0]  rsp_final_code;
   logic        rsp_private_flag;
   logic [4:0]  rsp_param_total;
   logic [3:0]  rsp_param_index;
   logic [15:0] rsp_param_value;
   logic [1:0]  rsp_sync_mode;
   logic        rsp_truncated;
   logic        rsp_last;

   csi_escape_sequence_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_command_type (rsp_command_type),
      .rsp_final_code   (rsp_final_code),
      .rsp_private_flag (rsp_private_flag),
      .rsp_param_total  (rsp_param_total),
      .rsp_param_index  (rsp_param_index),
      .rsp_param_value  (rsp_param_value),
      .rsp_sync_mode    (rsp_sync_mode),
      .rsp_truncated    (rsp_truncated),
      .rsp_last         (rsp_last)
   );

   always #1 clock = ~clock;

   // Parser state mirrored by the testbench.
   phase_type   seq_phase = PH_GROUND;
   logic [15:0] param_store [PARAM_SLOTS];
   int unsigned param_count = 0;
   logic        seen_private = 1'b0;
   logic        seen_bang = 1'b0;
   logic        seen_overflow = 1'b0;

   csi_result_type  predicted_commands[$];
   stream_byte_type byte_stream[$];
   bit              drain_before_next = 1'b0;
   string           command_finals = "ABCDEFGHJKSTfmnhlsup";

   int bytes_queued = 0;
   int bytes_taken = 0;
   int results_checked = 0;
   int parse_errors = 0;
   int sync_marks = 0;
   int mismatches = 0;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   task automatic restart_sequence();
      seq_phase     = PH_GROUND;
      param_count   = 0;
      seen_private  = 1'b0;
      seen_bang     = 1'b0;
      seen_overflow = 1'b0;
   endtask

   task automatic store_param(input int value);
      if (param_count < PARAM_SLOTS) begin
         param_store[param_count] = value[15:0];
         param_count++;
      end else begin
         seen_overflow = 1'b1;
      end
   endtask

   task automatic emit_error(input logic [7:0] b);
      csi_result_type r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.final_code = b;
      r.last       = 1'b1;
      predicted_commands.push_back(r);
      restart_sequence();
   endtask

   // A final byte closes the sequence with one item per stored parameter, or a single item when none is stored.
   task automatic emit_command(input logic [7:0] f);
      csi_result_type r;
      logic [4:0]  cmd;
      logic [1:0]  sync;
      int          n;
      int          k;
      case (f)
         "A":     cmd = CMD_CUU;
         "B":     cmd = CMD_CUD;
         "C":     cmd = CMD_CUF;
         "D":     cmd = CMD_CUB;
         "E":     cmd = CMD_CNL;
         "F":     cmd = CMD_CPL;
         "G":     cmd = CMD_CHA;
         "H":     cmd = CMD_CUP;
         "J":     cmd = CMD_ED;
         "K":     cmd = CMD_EL;
         "S":     cmd = CMD_SU;
         "T":     cmd = CMD_SD;
         "f":     cmd = CMD_HVP;
         "m":     cmd = CMD_SGR;
         "n":     cmd = CMD_DSR;
         "h":     cmd = seen_private ? CMD_PRIV_SET : CMD_SM;
         "l":     cmd = seen_private ? CMD_PRIV_RESET : CMD_RM;
         "s":     cmd = CMD_SAVE;
         "u":     cmd = CMD_RESTORE;
         "p":     cmd = seen_bang ? CMD_SOFT_RESET : CMD_UNKNOWN;
         default: cmd = CMD_UNKNOWN;
      endcase
      // Only the private 2026 set/reset pair marks synchronized output.
      sync = SYNC_NONE;
      if (seen_private && param_count != 0 && param_store[0] == SYNC_PARAM) begin
         if (cmd == CMD_PRIV_SET) sync = SYNC_ENABLE;
         else if (cmd == CMD_PRIV_RESET) sync = SYNC_DISABLE;
      end
      n = (param_count != 0) ? param_count : 1;
      for (k = 0; k < n; k++) begin
         r              = '0;
         r.kind         = KIND_COMMAND;
         r.command_type = cmd;
         r.final_code   = f;
         r.private_flag = seen_private;
         r.param_total  = param_count[4:0];
         r.param_index  = k[3:0];
         r.param_value  = (param_count != 0) ? param_store[k] : 16'd0;
         r.sync_mode    = sync;
         r.truncated    = seen_overflow;
         r.last         = (k == n - 1);
         predicted_commands.push_back(r);
      end
      restart_sequence();
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic is_digit;
      logic is_inter;
      logic is_final;
      int   acc;
      is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
      is_inter = (b >= INTER_LO) && (b <= INTER_HI);
      is_final = (b >= FINAL_LO) && (b <= FINAL_HI);
      case (seq_phase)
         PH_GROUND: begin
            if (b == CH_ESC) seq_phase = PH_ESCAPE;
         end
         PH_ESCAPE: begin
            restart_sequence();
            if (b == CH_LBRACKET) seq_phase = PH_ENTRY;
         end
         PH_ENTRY, PH_PARAM: begin
            if (seq_phase == PH_ENTRY && b == CH_QMARK && !seen_private) begin
               seen_private = 1'b1;
            end else if (is_digit) begin
               // The first digit opens a parameter; later ones extend it.
               if (seq_phase == PH_ENTRY) begin
                  store_param(b - CH_ZERO);
               end else if (!seen_overflow && param_count != 0) begin
                  acc = param_store[param_count - 1] * 10 + (b - CH_ZERO);
                  if (acc > VALUE_MAX) acc = VALUE_MAX;
                  param_store[param_count - 1] = acc[15:0];
               end
               seq_phase = PH_PARAM;
            end else if (b == CH_SEMI) begin
               store_param(0);
               seq_phase = PH_PARAM;
            end else if (is_inter) begin
               if (b == CH_BANG) seen_bang = 1'b1;
               seq_phase = PH_INTER;
            end else if (is_final) begin
               emit_command(b);
            end else begin
               emit_error(b);
            end
         end
         PH_INTER: begin
            if (is_inter) begin
               if (b == CH_BANG) seen_bang = 1'b1;
            end else if (is_final) begin
               emit_command(b);
            end else begin
               emit_error(b);
            end
         end
         default: restart_sequence();
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic put_byte(input logic [7:0] b);
      stream_byte_type item;
      item.data         = b;
      item.drain_first  = drain_before_next;
      drain_before_next = 1'b0;
      byte_stream.push_back(item);
      bytes_queued++;
   endtask

   task automatic send_csi(input string body);
      int i;
      put_byte(CH_ESC);
      put_byte(CH_LBRACKET);
      for (i = 0; i < body.len(); i++) put_byte(body[i]);
   endtask

   // Mostly well-formed sequences with random content, plus noise and cut-off ones.
   task automatic send_random_sequence();
      logic [7:0] seq[$];
      int         pick;
      int         nparams;
      int         i;
      int         cut;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
         return;
      end
      if (pick < 12) begin
         put_byte(CH_ESC);
         put_byte(8'($urandom_range(0, 255)));
         return;
      end
      seq = {CH_ESC, CH_LBRACKET};
      if ($urandom_range(0, 2) == 0) seq.push_back(CH_QMARK);
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5: nparams = 0;
         18:               nparams = $urandom_range(5, 16);
         19:               nparams = $urandom_range(17, 20);
         default:          nparams = $urandom_range(1, 4);
      endcase
      for (i = 0; i < nparams; i++) begin
         if (i > 0) seq.push_back(CH_SEMI);
         case ($urandom_range(0, 9))
            0: ;
            1: seq = {seq, "2", "0", "2", "6"};
            2: repeat ($urandom_range(5, 7))
               seq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            default: repeat ($urandom_range(1, 3))
               seq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         endcase
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2))
            seq.push_back(($urandom_range(0, 1) == 0) ? CH_BANG
                                                     : 8'($urandom_range(INTER_LO, INTER_HI)));
      end
      if ($urandom_range(0, 3) != 0)
         seq.push_back(command_finals[$urandom_range(0, command_finals.len() - 1)]);
      else
         seq.push_back(8'($urandom_range(FINAL_LO, FINAL_HI)));
      // Broken sequences: cut somewhere after ESC [ and end on an arbitrary byte.
      if (pick < 27) begin
         cut = $urandom_range(2, seq.size() - 1);
         while (seq.size() > cut) void'(seq.pop_back());
         seq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (seq[j]) put_byte(seq[j]);
   endtask

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // ------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------

   int              send_gap = 0;
   int              send_calm = 0;
   logic            offer;
   stream_byte_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            parse_byte(req_data_byte);
            bytes_taken++;
            offer = 1'b0;
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else if ($urandom_range(0, 49) == 0) begin
               send_calm = $urandom_range(20, 80);
            end else begin
               send_gap = draw_gap();
            end
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (byte_stream.size() != 0 &&
                         !(byte_stream[0].drain_first && predicted_commands.size() != 0)) begin
               next_byte = byte_stream.pop_front();
               req_data_byte <= next_byte.data;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // ------------------------------------------------------------------
   // Monitor and checker
   // ------------------------------------------------------------------

   function automatic string show(input csi_result_type r);
      return $sformatf({"kind=%0d cmd=%0d final=%02h priv=%0d total=%0d idx=%0d ",
                        "value=%0d sync=%0d trunc=%0d last=%0d"},
                       r.kind, r.command_type, r.final_code, r.private_flag,
                       r.param_total, r.param_index, r.param_value, r.sync_mode,
                       r.truncated, r.last);
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", what);
   endtask

   int             hold_left = 0;
   bit             hold_done = 1'b0;
   int             stall_left = 0;
   int             stall_calm = 0;
   logic           hold_off;
   csi_result_type got;
   csi_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_kind, rsp_command_type, rsp_final_code, rsp_private_flag,
                   rsp_param_total, rsp_param_index, rsp_param_value, rsp_sync_mode,
                   rsp_truncated, rsp_last};
            results_checked++;
            if (got.kind == KIND_ERROR) parse_errors++;
            if (got.sync_mode != SYNC_NONE) sync_marks++;
            if (predicted_commands.size() == 0) begin
               note_mismatch($sformatf("unexpected item %s", show(got)));
            end else begin
               want = predicted_commands.pop_front();
               if (got !== want)
                  note_mismatch($sformatf("expected %s\n          got %s",
                                          show(want), show(got)));
            end
         end
         // One long hold-off midway so the parser backs up into its input.
         if (hold_left > 0) begin
            hold_left--;
            hold_off = 1'b1;
         end else if (!hold_done && bytes_taken >= 250) begin
            hold_done = 1'b1;
            hold_left = 300;
            hold_off  = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            hold_off = 1'b1;
         end else begin
            hold_off = 1'b0;
            if (stall_calm > 0) stall_calm--;
            else if ($urandom_range(0, 49) == 0) stall_calm = $urandom_range(20, 80);
            else stall_left = draw_gap();
         end
         rsp_stall <= hold_off;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   int seq_count;

   initial begin
      seq_count = 0;

      // Plain text is ignored, and ESC followed by anything but '[' drops back.
      put_byte("h");
      put_byte(8'h0A);
      put_byte(CH_ESC);
      put_byte("X");
      send_csi("A");
      // Synchronized output on and off, and near misses.
      send_csi("?2026h");
      send_csi("?2026l");
      send_csi("?2026;1h");
      send_csi("?25l");
      send_csi("2026h");
      // Saturation, empty parameters and more parameters than slots.
      send_csi("99999m");
      send_csi(";;H");
      send_csi("1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18m");
      send_csi("65535;65536;0f");
      // Soft reset needs the bang; intermediates and the final byte extremes.
      send_csi("!p");
      send_csi("p");
      send_csi(" $@");
      send_csi("~");
      // Breaking bytes: second '?', '?' after a digit, digit after an
      // intermediate, ESC inside a sequence, and high bytes.
      send_csi("??h");
      send_csi("1?h");
      send_csi("1!2");
      send_csi("5");
      put_byte(CH_ESC);
      send_csi("3");
      put_byte(8'h80);
      send_csi("");
      put_byte(8'hFF);
      // ESC twice drops back to ground, so the following '[' and 'B' are plain text.
      put_byte(CH_ESC);
      send_csi("B");
      // Every command letter once.
      for (int i = 0; i < command_finals.len(); i++) begin
         put_byte(CH_ESC);
         put_byte(CH_LBRACKET);
         put_byte("3");
         put_byte(command_finals[i]);
      end

      // Random part, with the sender draining now and then.
      drain_before_next = 1'b1;
      while (bytes_queued < BYTE_BUDGET) begin
         seq_count++;
         if (seq_count % 25 == 0) drain_before_next = 1'b1;
         send_random_sequence();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (byte_stream.size() != 0 || req_valid || predicted_commands.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (predicted_commands.size() != 0)
         note_mismatch($sformatf("%0d items never arrived", predicted_commands.size()));

      $display("Sent %0d bytes of directed and random CSI traffic; checked %0d items,",
               bytes_taken, results_checked);
      $display("of them %0d parse errors and %0d synchronized-output marks.",
               parse_errors, sync_marks);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/csiesc_pkg.sv
src/csiesc_ram.sv
src/csi_escape_sequence_parser.sv
verif/testbench.sv
